[hw/rtl/sbb_pkg.sv]
// sbb_pkg: widths, register indexes, divider word and sequencer state types
// for the separable box blur unit. Depends on nothing.
package sbb_pkg;

	localparam int PIX_W     = 8;
	localparam int KS_W      = 6;
	localparam int DIM_W     = 12;
	localparam int POS_W     = 11;
	localparam int SUM_W     = 14;
	localparam int CFG_IDX_W = 2;
	localparam int ROW_LIMIT = 2048;
	localparam int DIV_STEPS = SUM_W;

	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

	localparam logic [KS_W-1:0]  KS_RESET = 6'd41;
	localparam logic [DIM_W-1:0] WD_RESET = 12'd640;
	localparam logic [DIM_W-1:0] HT_RESET = 12'd480;

	typedef enum logic [1:0] {
		OP_RMOD,
		OP_CMOD,
		OP_VMEAN,
		OP_HMEAN
	} div_op_t;

	// dq starts as the dividend and ends as the quotient
	typedef struct packed {
		div_op_t         op;
		logic [SUM_W-1:0] dq;
		logic [KS_W-1:0]  rem;
		logic [KS_W-1:0]  d;
	} div_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD_R,
		ST_MOD_C,
		ST_MOD_WAIT,
		ST_READ,
		ST_VMEAN,
		ST_HMEAN,
		ST_EMIT
	} state_t;

endpackage

[hw/rtl/sbb_if.sv]
// sbb_if: valid/ready stream interfaces for pixel requests and blur results.
// Depends on sbb_pkg for field widths.
interface sbb_in_if;
	logic                      valid;
	logic                      ready;
	logic [sbb_pkg::PIX_W-1:0] pixel;
	logic                      frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface sbb_out_if;
	logic                      valid;
	logic                      ready;
	logic [sbb_pkg::PIX_W-1:0] blurred_value;
	logic [sbb_pkg::POS_W-1:0] out_row;
	logic [sbb_pkg::POS_W-1:0] out_col;
	logic                      frame_last;

	modport source (output valid, output blurred_value, output out_row, output out_col,
		output frame_last, input ready);
	modport sink (input valid, input blurred_value, input out_row, input out_col,
		input frame_last, output ready);
endinterface

[hw/rtl/sbb_div_cell.sv]
// sbb_div_cell: one restoring division step, registered, handing its word on.
// Depends on sbb_pkg for the divider word type.
module sbb_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  sbb_pkg::div_word_t in_word,
	output logic              out_valid,
	output sbb_pkg::div_word_t out_word
);

	logic [sbb_pkg::KS_W:0] rem2;
	logic                   ge;
	sbb_pkg::div_word_t     nxt;
	logic                   valid_q;
	sbb_pkg::div_word_t     word_q;

	always_comb begin
		rem2 = {in_word.rem, in_word.dq[sbb_pkg::SUM_W-1]};
		ge = rem2 >= {1'b0, in_word.d};
		nxt = in_word;
		nxt.dq = {in_word.dq[sbb_pkg::SUM_W-2:0], ge};
		nxt.rem = ge ? sbb_pkg::KS_W'(rem2 - {1'b0, in_word.d}) : rem2[sbb_pkg::KS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_word = word_q;

endmodule

[hw/rtl/sbb_div_chain.sv]
// sbb_div_chain: row of division cells, one quotient bit per cell per cycle.
// Depends on sbb_pkg and sbb_div_cell.
module sbb_div_chain (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  sbb_pkg::div_word_t in_word,
	output logic              out_valid,
	output sbb_pkg::div_word_t out_word
);

	logic               v [0:sbb_pkg::DIV_STEPS];
	sbb_pkg::div_word_t w [0:sbb_pkg::DIV_STEPS];

	assign v[0] = in_valid;
	assign w[0] = in_word;

	for (genvar i = 0; i < sbb_pkg::DIV_STEPS; i++) begin : g_cell
		sbb_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[i]),
			.in_word   (w[i]),
			.out_valid (v[i+1]),
			.out_word  (w[i+1])
		);
	end

	assign out_valid = v[sbb_pkg::DIV_STEPS];
	assign out_word = w[sbb_pkg::DIV_STEPS];

endmodule

[hw/rtl/separable_box_blur_unit.sv]
// separable_box_blur_unit: K by K box blur over a raster pixel stream, with
// line store, column sums, mean window and sequencer. Depends on sbb_pkg,
// sbb_if and sbb_div_chain.
//
// Usage: pixel requests come in on pixels (valid/ready), raster order, with
// frame_start on the first pixel of a frame. For each pixel that completes a
// window, one result with the centre coordinates goes out on results; border
// pixels produce nothing. Registers kernel_size, image_width, image_height are
// written through cfg_we/cfg_index/cfg_data, by the user only while the block
// is idle; the block itself does not enforce this. One pixel at a time: in the
// first K-1 rows a pixel passes only the idle and read states; when only the
// vertical mean is taken, or a result is made, it waits on the 14-cell divider
// chain, passed once per mean. The result sits in an output register, so the
// next pixel is taken while it waits; a stalled receiver holds the block only
// when a second result is ready. After reset the column sums are cleared, one
// entry a cycle, with pixels held off. A kernel_size write starts a recompute
// of the row and column slots, which ends before the next pixel is taken.
module separable_box_blur_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_KERNEL = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sbb_in_if.sink                        pixels,
	sbb_out_if.source                     results,
	input  logic                          cfg_we,
	input  logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbb_pkg::DIM_W-1:0]     cfg_data
);

	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int KW       = $clog2(MAX_KERNEL);
	localparam int LS_DEPTH = MAX_KERNEL * (2 ** CW);

	localparam int PW = sbb_pkg::PIX_W;
	localparam int KS = sbb_pkg::KS_W;
	localparam int SW = sbb_pkg::SUM_W;
	localparam int RW = sbb_pkg::POS_W;

	// configuration
	logic [KS-1:0]               ks_q;
	logic [sbb_pkg::DIM_W-1:0]   wd_q, ht_q;
	logic [KS-1:0]               k;
	logic [CW:0]                 w;
	logic [sbb_pkg::DIM_W-1:0]   h;

	// position and slot counters
	logic [RW-1:0] pos_r_q;
	logic [CW-1:0] pos_c_q;
	logic [KS-1:0] rmod_q, cmod_q;
	logic          stale_q;

	// adjusted and advanced position
	logic [RW:0]   a_r;
	logic [CW-1:0] a_c;
	logic [KS-1:0] a_rm, a_cm;
	logic [RW-1:0] n_r;
	logic [CW-1:0] n_c;
	logic [KS-1:0] n_rm, n_cm;

	// current item
	logic [PW-1:0] px_q;
	logic [CW-1:0] cur_c_q;
	logic [KS-1:0] cur_rm_q, cur_cm_q;
	logic          r_zero_q, r_ge_k_q, vert_ok_q;
	logic          c_zero_q, c_ge_k_q, horiz_ok_q;
	logic          last_q;
	logic [RW-1:0] row_o_q, col_o_q;
	logic [PW-1:0] hq_q;

	// memories
	logic [SW-1:0] cs_mem [0:MAX_WIDTH-1];
	logic [PW-1:0] ls_mem [0:LS_DEPTH-1];
	logic [PW-1:0] mw_mem [0:MAX_KERNEL-1];
	logic [MAX_KERNEL-1:0] mw_vld_q;
	logic [SW-1:0] cs_rd_q;
	logic [PW-1:0] ls_rd_q, mw_rd_q;
	logic          mw_vld_rd_q;
	logic [PW-1:0] mw_old;
	logic [CW-1:0] clr_q;
	logic          clr_done;
	logic [CW-1:0] cs_waddr;
	logic [SW-1:0] cs_wdata;

	logic [SW-1:0] row_sum_q;
	logic [SW-1:0] cs_new, rs_new;
	logic [PW-1:0] vm;

	// divider
	logic               div_valid;
	sbb_pkg::div_op_t   div_op;
	sbb_pkg::div_word_t div_word;
	logic               dres_valid;
	sbb_pkg::div_word_t dres_word;
	logic               vres, hres, cres;

	// sequencer
	sbb_pkg::state_t state_q, state_d;
	logic in_accept;
	logic cs_we, ls_we, mw_we, out_load;

	logic          ov_q;
	logic [PW-1:0] ob_q;
	logic [RW-1:0] orow_q, ocol_q;
	logic          olast_q;

	always_comb begin
		if (ks_q == '0) begin
			k = KS'(1);
		end else if (32'(ks_q) > MAX_KERNEL) begin
			k = KS'(MAX_KERNEL);
		end else begin
			k = ks_q;
		end
		if (wd_q == '0) begin
			w = (CW+1)'(1);
		end else if (32'(wd_q) > MAX_WIDTH) begin
			w = (CW+1)'(MAX_WIDTH);
		end else begin
			w = (CW+1)'(wd_q);
		end
		if (ht_q == '0) begin
			h = sbb_pkg::DIM_W'(1);
		end else if (32'(ht_q) > sbb_pkg::ROW_LIMIT) begin
			h = sbb_pkg::DIM_W'(sbb_pkg::ROW_LIMIT);
		end else begin
			h = ht_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q <= sbb_pkg::KS_RESET;
			wd_q <= sbb_pkg::WD_RESET;
			ht_q <= sbb_pkg::HT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == sbb_pkg::CFG_KERNEL_SIZE) begin
				ks_q <= cfg_data[KS-1:0];
			end
			if (cfg_index == sbb_pkg::CFG_IMAGE_WIDTH) begin
				wd_q <= cfg_data;
			end
			if (cfg_index == sbb_pkg::CFG_IMAGE_HEIGHT) begin
				ht_q <= cfg_data;
			end
		end
	end

	// position wrap on entry, then advance past this pixel
	always_comb begin
		if (pixels.frame_start) begin
			a_r = '0;
			a_c = '0;
			a_rm = '0;
			a_cm = '0;
		end else begin
			a_r = {1'b0, pos_r_q};
			a_c = pos_c_q;
			a_rm = rmod_q;
			a_cm = cmod_q;
		end
		if (32'(a_c) >= 32'(w)) begin
			a_c = '0;
			a_cm = '0;
			a_r = a_r + 1'b1;
			a_rm = (a_rm == k - 1'b1) ? '0 : a_rm + 1'b1;
		end
		if (32'(a_r) >= 32'(h)) begin
			a_r = '0;
			a_rm = '0;
		end
		if (32'(a_c) + 1 >= 32'(w)) begin
			n_c = '0;
			n_cm = '0;
			if (32'(a_r) + 1 >= 32'(h)) begin
				n_r = '0;
				n_rm = '0;
			end else begin
				n_r = RW'(a_r + 1'b1);
				n_rm = (a_rm == k - 1'b1) ? '0 : a_rm + 1'b1;
			end
		end else begin
			n_c = a_c + 1'b1;
			n_cm = (a_cm == k - 1'b1) ? '0 : a_cm + 1'b1;
			n_r = RW'(a_r);
			n_rm = a_rm;
		end
	end

	assign in_accept = pixels.valid && pixels.ready;

	assign vres = dres_valid && (dres_word.op == sbb_pkg::OP_VMEAN);
	assign hres = dres_valid && (dres_word.op == sbb_pkg::OP_HMEAN);
	assign cres = dres_valid && (dres_word.op == sbb_pkg::OP_CMOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_r_q <= '0;
			pos_c_q <= '0;
			rmod_q <= '0;
			cmod_q <= '0;
			stale_q <= 1'b0;
		end else begin
			if (in_accept) begin
				pos_r_q <= n_r;
				pos_c_q <= n_c;
				rmod_q <= n_rm;
				cmod_q <= n_cm;
			end
			if (dres_valid && dres_word.op == sbb_pkg::OP_RMOD) begin
				rmod_q <= dres_word.rem;
			end
			if (cres) begin
				cmod_q <= dres_word.rem;
			end
			if (cfg_we && cfg_index == sbb_pkg::CFG_KERNEL_SIZE) begin
				stale_q <= 1'b1;
			end else if (state_q == sbb_pkg::ST_MOD_R) begin
				stale_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_q <= pixels.pixel;
			cur_c_q <= a_c;
			cur_rm_q <= a_rm;
			cur_cm_q <= a_cm;
			r_zero_q <= (a_r == '0);
			r_ge_k_q <= 32'(a_r) >= 32'(k);
			vert_ok_q <= 32'(a_r) + 1 >= 32'(k);
			c_zero_q <= (a_c == '0);
			c_ge_k_q <= 32'(a_c) >= 32'(k);
			horiz_ok_q <= 32'(a_c) + 1 >= 32'(k);
			last_q <= (32'(a_r) == 32'(h) - 1) && (32'(a_c) == 32'(w) - 1);
			row_o_q <= RW'(a_r) - RW'(k) + RW'(1) + RW'(k >> 1);
			col_o_q <= RW'(a_c) - RW'(k) + RW'(1) + RW'(k >> 1);
		end
		if (hres) begin
			hq_q <= dres_word.dq[PW-1:0];
		end
	end

	// sums
	assign mw_old = mw_vld_rd_q ? mw_rd_q : '0;
	assign vm = dres_word.dq[PW-1:0];

	always_comb begin
		if (r_zero_q) begin
			cs_new = SW'(px_q);
		end else begin
			cs_new = SW'(32'(cs_rd_q) + 32'(px_q) - (r_ge_k_q ? 32'(ls_rd_q) : 32'd0));
		end
		if (c_zero_q) begin
			rs_new = SW'(vm);
		end else begin
			rs_new = SW'(32'(row_sum_q) + 32'(vm) - (c_ge_k_q ? 32'(mw_old) : 32'd0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
		end else if (state_q == sbb_pkg::ST_VMEAN && vres) begin
			row_sum_q <= rs_new;
		end
	end

	// column sums: cleared once after reset
	assign clr_done = (clr_q == CW'(MAX_WIDTH - 1));
	assign cs_waddr = (state_q == sbb_pkg::ST_CLEAR) ? clr_q : cur_c_q;
	assign cs_wdata = (state_q == sbb_pkg::ST_CLEAR) ? '0 : cs_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == sbb_pkg::ST_CLEAR && !clr_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cs_we) begin
			cs_mem[cs_waddr] <= cs_wdata;
		end
		cs_rd_q <= cs_mem[a_c];
	end

	always_ff @(posedge clk) begin
		if (ls_we) begin
			ls_mem[{KW'(cur_rm_q), cur_c_q}] <= px_q;
		end
		ls_rd_q <= ls_mem[{KW'(a_rm), a_c}];
	end

	// old mean is held from the pixel request until the vertical mean returns
	always_ff @(posedge clk) begin
		if (mw_we) begin
			mw_mem[KW'(cur_cm_q)] <= vm;
		end
		if (in_accept) begin
			mw_rd_q <= mw_mem[KW'(a_cm)];
			mw_vld_rd_q <= mw_vld_q[KW'(a_cm)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_vld_q <= '0;
		end else if (mw_we) begin
			mw_vld_q[KW'(cur_cm_q)] <= 1'b1;
		end
	end

	// divider request
	always_comb begin
		div_word.op = div_op;
		div_word.rem = '0;
		div_word.d = k;
		case (div_op)
			sbb_pkg::OP_RMOD:  div_word.dq = SW'(pos_r_q);
			sbb_pkg::OP_CMOD:  div_word.dq = SW'(pos_c_q);
			sbb_pkg::OP_VMEAN: div_word.dq = cs_new;
			default:           div_word.dq = rs_new;
		endcase
	end

	sbb_div_chain u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_word   (div_word),
		.out_valid (dres_valid),
		.out_word  (dres_word)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sbb_pkg::ST_CLEAR: begin
				if (clr_done) state_d = sbb_pkg::ST_IDLE;
			end
			sbb_pkg::ST_IDLE: begin
				if (stale_q) state_d = sbb_pkg::ST_MOD_R;
				else if (pixels.valid) state_d = sbb_pkg::ST_READ;
			end
			sbb_pkg::ST_MOD_R: state_d = sbb_pkg::ST_MOD_C;
			sbb_pkg::ST_MOD_C: state_d = sbb_pkg::ST_MOD_WAIT;
			sbb_pkg::ST_MOD_WAIT: begin
				if (cres) state_d = sbb_pkg::ST_IDLE;
			end
			sbb_pkg::ST_READ: begin
				state_d = vert_ok_q ? sbb_pkg::ST_VMEAN : sbb_pkg::ST_IDLE;
			end
			sbb_pkg::ST_VMEAN: begin
				if (vres) state_d = horiz_ok_q ? sbb_pkg::ST_HMEAN : sbb_pkg::ST_IDLE;
			end
			sbb_pkg::ST_HMEAN: begin
				if (hres) state_d = sbb_pkg::ST_EMIT;
			end
			sbb_pkg::ST_EMIT: begin
				if (!ov_q || results.ready) state_d = sbb_pkg::ST_IDLE;
			end
			default: state_d = sbb_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		pixels.ready = 1'b0;
		cs_we = 1'b0;
		ls_we = 1'b0;
		mw_we = 1'b0;
		div_valid = 1'b0;
		div_op = sbb_pkg::OP_VMEAN;
		out_load = 1'b0;
		unique case (state_q)
			sbb_pkg::ST_CLEAR: cs_we = 1'b1;
			sbb_pkg::ST_IDLE: pixels.ready = !stale_q;
			sbb_pkg::ST_MOD_R: begin
				div_valid = 1'b1;
				div_op = sbb_pkg::OP_RMOD;
			end
			sbb_pkg::ST_MOD_C: begin
				div_valid = 1'b1;
				div_op = sbb_pkg::OP_CMOD;
			end
			sbb_pkg::ST_MOD_WAIT: ;
			sbb_pkg::ST_READ: begin
				cs_we = 1'b1;
				ls_we = 1'b1;
				div_valid = vert_ok_q;
				div_op = sbb_pkg::OP_VMEAN;
			end
			sbb_pkg::ST_VMEAN: begin
				mw_we = vres;
				div_valid = vres && horiz_ok_q;
				div_op = sbb_pkg::OP_HMEAN;
			end
			sbb_pkg::ST_HMEAN: ;
			sbb_pkg::ST_EMIT: out_load = !ov_q || results.ready;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (results.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ob_q <= hq_q;
			orow_q <= row_o_q;
			ocol_q <= col_o_q;
			olast_q <= last_q;
		end
	end

	assign results.valid = ov_q;
	assign results.blurred_value = ob_q;
	assign results.out_row = orow_q;
	assign results.out_col = ocol_q;
	assign results.frame_last = olast_q;

`ifndef SYNTHESIS
	a_slots_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> (rmod_q < k) && (cmod_q < k))
		else $error("row or column slot not below kernel size at pixel request");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!ov_q || results.ready))
		else $error("output register overwritten while full");

	a_vmean_state: assert property (@(posedge clk) disable iff (!arst_n)
		vres |-> state_q == sbb_pkg::ST_VMEAN)
		else $error("vertical mean returned outside its wait state");

	a_hmean_state: assert property (@(posedge clk) disable iff (!arst_n)
		hres |-> state_q == sbb_pkg::ST_HMEAN)
		else $error("horizontal mean returned outside its wait state");
`endif

endmodule

[tb/sv/separable_box_blur_unit_tb.sv]
// separable_box_blur_unit_tb: self-checking bench for the box blur unit, with
// its own blur predictor, stream drivers and result checker.
// Depends on sbb_pkg, sbb_if and the separable_box_blur_unit RTL.
module separable_box_blur_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW = 2048;
	localparam int MAXK = 63;
	localparam int STUCK_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [sbb_pkg::PIX_W-1:0] value;
		logic [sbb_pkg::POS_W-1:0] row;
		logic [sbb_pkg::POS_W-1:0] col;
		logic                      last;
	} blur_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sbb_pkg::DIM_W-1:0] cfg_data;

	sbb_in_if pix_if ();
	sbb_out_if res_if ();

	separable_box_blur_unit DUT (
		.clk(clk), .arst_n(arst_n), .pixels(pix_if), .results(res_if),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	bit [7:0] line_mem [MAXK*MAXW];
	bit [13:0] col_sum [MAXW];
	bit [7:0] mean_win [MAXK];
	bit [13:0] horiz_sum;
	int cur_row, cur_col;
	bit [5:0] kernel_reg;
	bit [11:0] width_reg, height_reg;
	blur_result_t pending_blur [$];

	int send_idle, recv_stall;
	int errors;
	int stuck;
	bit hold_req;
	int hold_left;
	int frame_w, frame_h;

	function automatic int clip(int v, int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void predict_blur(input logic [7:0] px, input logic fs);
		int k, w, h, r, c, slot, ms, s;
		bit [7:0] vm;
		blur_result_t e;
		k = clip(int'(kernel_reg), MAXK);
		w = clip(int'(width_reg), MAXW);
		h = clip(int'(height_reg), sbb_pkg::ROW_LIMIT);
		if (fs) begin
			cur_row = 0;
			cur_col = 0;
		end
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row++;
		end
		if (cur_row >= h) cur_row = 0;
		r = cur_row;
		c = cur_col;
		slot = (r % k) * MAXW + c;
		if (r == 0) begin
			col_sum[c] = 14'(px);
		end else begin
			s = int'(col_sum[c]) + int'(px);
			if (r >= k) s = s - int'(line_mem[slot]);
			col_sum[c] = 14'(s & 'h3FFF);
		end
		line_mem[slot] = px;
		if (r + 1 >= k) begin
			vm = 8'(int'(col_sum[c]) / k);
			ms = c % k;
			if (c == 0) begin
				horiz_sum = 14'(vm);
			end else begin
				s = int'(horiz_sum) + int'(vm);
				if (c >= k) s = s - int'(mean_win[ms]);
				horiz_sum = 14'(s & 'h3FFF);
			end
			mean_win[ms] = vm;
			if (c + 1 >= k) begin
				e.value = 8'(int'(horiz_sum) / k);
				e.row = sbb_pkg::POS_W'(r - k + 1 + k / 2);
				e.col = sbb_pkg::POS_W'(c - k + 1 + k / 2);
				e.last = (r == h - 1 && c == w - 1);
				pending_blur.push_back(e);
			end
		end
		if (c + 1 >= w) begin
			cur_col = 0;
			cur_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			cur_col = c + 1;
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_pixel(input logic [7:0] px, input logic fs);
		while ($urandom_range(99) < send_idle) begin
			pix_if.valid <= 1'b0;
			@(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pixel <= px;
		pix_if.frame_start <= fs;
		do @(posedge clk); while (!pix_if.ready);
		predict_blur(px, fs);
		@(negedge clk);
	endtask

	// drop valid, wait for all results plus the tail of a silent pixel
	task automatic drain;
		pix_if.valid <= 1'b0;
		while (pending_blur.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [sbb_pkg::CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= sbb_pkg::DIM_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sbb_pkg::CFG_KERNEL_SIZE: kernel_reg = val[5:0];
			sbb_pkg::CFG_IMAGE_WIDTH: width_reg = val[11:0];
			sbb_pkg::CFG_IMAGE_HEIGHT: height_reg = val[11:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_frame(input int k, input int w, input int h);
		write_reg(sbb_pkg::CFG_KERNEL_SIZE, k);
		write_reg(sbb_pkg::CFG_IMAGE_WIDTH, w);
		write_reg(sbb_pkg::CFG_IMAGE_HEIGHT, h);
		frame_w = clip(w, MAXW);
		frame_h = clip(h, sbb_pkg::ROW_LIMIT);
	endtask

	function automatic logic [7:0] pick_pixel;
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// up to n pixels of the current frame, frame_start on the first when mark is set
	task automatic send_frame(input int n, input bit mark);
		for (int i = 0; i < n && i < frame_w * frame_h; i++)
			send_pixel(pick_pixel(), mark && i == 0);
	endtask

	task automatic test_reset_defaults;
		// reset config is 41x41 over 640x480, so a few pixels give nothing
		frame_w = 640;
		frame_h = 480;
		send_frame(12, 1'b1);
		drain();
	endtask

	task automatic test_directed;
		set_frame(0, 3, 2);           // kernel zero acts as one
		send_frame(6, 1'b1);
		drain();
		set_frame(63, 4, 4);          // kernel larger than the frame
		send_frame(16, 1'b1);
		drain();
		set_frame(4, 5, 5);           // even kernel
		send_frame(25, 1'b1);
		drain();
		set_frame(1, 0, 0);           // zero sizes act as one
		send_frame(1, 1'b1);
		send_frame(1, 1'b0);
		drain();
		set_frame(67, 3, 3);          // only the low kernel bits count
		send_frame(9, 1'b1);
		send_frame(9, 1'b0);          // wraps without frame_start
		drain();
		set_frame(1, 4095, 1);        // width saturates
		send_frame(30, 1'b1);
		drain();
		set_frame(1, 1, 4095);        // height saturates
		send_frame(20, 1'b1);
		drain();
		set_frame(63, 2048, 2048);
		send_frame(10, 1'b1);
		drain();
	endtask

	task automatic test_random_phase(input int idle, input int stall, input int n);
		int sent, mode, len;
		send_idle = idle;
		recv_stall = stall;
		case ($urandom_range(5))
			0: set_frame(1, $urandom_range(1, 10), $urandom_range(1, 8));
			1: set_frame(2, $urandom_range(2, 12), $urandom_range(2, 10));
			default: set_frame(2 * $urandom_range(1, 3) + 1, $urandom_range(3, 12),
				$urandom_range(3, 10));
		endcase
		sent = 0;
		while (sent < n) begin
			mode = $urandom_range(19);
			if (mode == 0) begin
				// noise: a lone pixel with random frame_start
				send_pixel(8'($urandom_range(255)), 1'($urandom_range(1)));
				sent++;
			end else if (mode == 1) begin
				// broken frame
				len = $urandom_range(1, frame_w * frame_h);
				send_frame(len, 1'b1);
				sent += len;
			end else begin
				send_frame(frame_w * frame_h, mode != 2);
				sent += frame_w * frame_h;
			end
		end
		drain();
	endtask

	task automatic test_backpressure;
		send_idle = 0;
		recv_stall = 0;
		set_frame(3, 6, 6);
		hold_req = 1'b1;
		send_frame(36, 1'b1);
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		blur_result_t e;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_blur.size() == 0) begin
				$error("unexpected result row %0d col %0d", res_if.out_row, res_if.out_col);
				errors++;
			end else begin
				e = pending_blur.pop_front();
				if (res_if.blurred_value !== e.value) begin
					$error("blurred_value expected %0d actual %0d", e.value,
						res_if.blurred_value);
					errors++;
				end
				if (res_if.out_row !== e.row) begin
					$error("out_row expected %0d actual %0d", e.row, res_if.out_row);
					errors++;
				end
				if (res_if.out_col !== e.col) begin
					$error("out_col expected %0d actual %0d", e.col, res_if.out_col);
					errors++;
				end
				if (res_if.frame_last !== e.last) begin
					$error("frame_last expected %0d actual %0d", e.last,
						res_if.frame_last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any request moving
	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
			stuck = 0;
		else
			stuck++;
		if (stuck >= STUCK_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_if.valid = 1'b0;
		pix_if.pixel = '0;
		pix_if.frame_start = 1'b0;
		res_if.ready = 1'b0;
		errors = 0;
		stuck = 0;
		hold_req = 1'b0;
		hold_left = 0;
		send_idle = 0;
		recv_stall = 0;
		kernel_reg = sbb_pkg::KS_RESET;
		width_reg = sbb_pkg::WD_RESET;
		height_reg = sbb_pkg::HT_RESET;
		horiz_sum = '0;
		cur_row = 0;
		cur_col = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_directed();
		test_backpressure();
		test_random_phase(0, 0, 90);
		test_random_phase(77, 0, 90);
		test_random_phase(0, 77, 90);
		test_random_phase(25, 25, 90);
		drain();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

[files.f]
hw/rtl/sbb_pkg.sv
hw/rtl/sbb_if.sv
hw/rtl/sbb_div_cell.sv
hw/rtl/sbb_div_chain.sv
hw/rtl/separable_box_blur_unit.sv
tb/sv/separable_box_blur_unit_tb.sv
